// ===== hdl/ipd_pkg.sv =====
`timescale 1ns / 1ps

package ipd_pkg;

	// Largest number of whole bytes decoded from one frame.
	localparam int MAX_BYTES = 16;
	localparam int BYTE_W    = $clog2(MAX_BYTES + 1);

	localparam int TICK_W    = 15;
	localparam int SYM_CNT_W = 12;
	localparam int CFG_IDX_W = 4;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_MARK  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SPACE = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BIT_MARK     = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_SPACE    = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_SPACE   = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE    = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_BITS     = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_BYTES    = 4'd7;

	// Frame status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SHORT = 2'd1;
	localparam logic [1:0] ST_FAIL  = 2'd2;

	// One received symbol.
	typedef struct packed {
		logic [TICK_W-1:0] mark_ticks;
		logic [TICK_W-1:0] space_ticks;
		logic              frame_end;
	} sym_t;

	// One decoded frame.
	typedef struct packed {
		logic [1:0]  status;
		logic        checksum_good;
		logic [4:0]  byte_count;
		logic [7:0]  command_byte;
		logic [31:0] first_word;
	} res_t;

	// Current configuration register contents.
	typedef struct packed {
		logic [TICK_W-1:0]    header_mark_ticks;
		logic [TICK_W-1:0]    header_space_ticks;
		logic [TICK_W-1:0]    bit_mark_ticks;
		logic [TICK_W-1:0]    one_space_ticks;
		logic [TICK_W-1:0]    zero_space_ticks;
		logic [TICK_W-1:0]    match_tolerance;
		logic [SYM_CNT_W-1:0] min_data_bits;
		logic [4:0]           min_frame_bytes;
	} cfg_t;

endpackage

// ===== hdl/ipd_cfg_regs.sv =====
`timescale 1ns / 1ps

module ipd_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ipd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ipd_pkg::TICK_W-1:0]    cfg_data,
	output ipd_pkg::cfg_t                 cfg
);
	import ipd_pkg::*;

	cfg_t cfg_q;

	// The register file takes a write in any cycle.
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Register writes; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_mark_ticks  <= 15'd3324;
			cfg_q.header_space_ticks <= 15'd1574;
			cfg_q.bit_mark_ticks     <= 15'd448;
			cfg_q.one_space_ticks    <= 15'd1182;
			cfg_q.zero_space_ticks   <= 15'd390;
			cfg_q.match_tolerance    <= 15'd150;
			cfg_q.min_data_bits      <= 12'd48;
			cfg_q.min_frame_bytes    <= 5'd6;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_HEADER_MARK:  cfg_q.header_mark_ticks  <= cfg_data;
				CFG_HEADER_SPACE: cfg_q.header_space_ticks <= cfg_data;
				CFG_BIT_MARK:     cfg_q.bit_mark_ticks     <= cfg_data;
				CFG_ONE_SPACE:    cfg_q.one_space_ticks    <= cfg_data;
				CFG_ZERO_SPACE:   cfg_q.zero_space_ticks   <= cfg_data;
				CFG_TOLERANCE:    cfg_q.match_tolerance    <= cfg_data;
				CFG_MIN_BITS:     cfg_q.min_data_bits      <= cfg_data[SYM_CNT_W-1:0];
				CFG_MIN_BYTES:    cfg_q.min_frame_bytes    <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== hdl/ipd_frame_state.sv =====
`timescale 1ns / 1ps

module ipd_frame_state (
	input  logic          clk,
	input  logic          arst_n,
	input  ipd_pkg::cfg_t cfg,
	input  logic          advance,
	input  ipd_pkg::sym_t sym,
	output ipd_pkg::res_t result
);
	import ipd_pkg::*;

	logic [SYM_CNT_W-1:0] symbol_count_q, symbol_count_nx;
	logic                 header_good_q, header_good_nx;
	logic [7:0]           shift_byte_q, shift_byte_nx;
	logic [2:0]           bit_position_q, bit_position_nx;
	logic                 pending_err_q, pending_err_nx;
	logic                 committed_err_q, committed_err_nx;
	logic [BYTE_W-1:0]    bytes_done_q, bytes_done_nx;
	logic [7:0]           byte_sum_q, byte_sum_nx;
	logic [7:0]           last_byte_q, last_byte_nx;
	logic [31:0]          low_word_q, low_word_nx;
	logic [7:0]           byte_zero_q, byte_zero_nx;
	logic [7:0]           byte_five_q, byte_five_nx;

	logic hdr_ok, mark_ok, one_ok, zero_ok;
	logic [7:0] shift_set;
	logic [7:0] expect_sum;
	logic [1:0] status;

	// True when a duration lies within the tolerance of its expected value.
	function automatic logic near_value(input logic [TICK_W-1:0] got,
	                                    input logic [TICK_W-1:0] want,
	                                    input logic [TICK_W-1:0] tol);
		logic [TICK_W-1:0] diff;
		diff = (got >= want) ? (got - want) : (want - got);
		return diff <= tol;
	endfunction

	// Duration matches, all in parallel.
	assign hdr_ok  = near_value(sym.mark_ticks, cfg.header_mark_ticks, cfg.match_tolerance) &&
	                 near_value(sym.space_ticks, cfg.header_space_ticks, cfg.match_tolerance);
	assign mark_ok = near_value(sym.mark_ticks, cfg.bit_mark_ticks, cfg.match_tolerance);
	assign one_ok  = near_value(sym.space_ticks, cfg.one_space_ticks, cfg.match_tolerance);
	assign zero_ok = near_value(sym.space_ticks, cfg.zero_space_ticks, cfg.match_tolerance);

	assign shift_set = shift_byte_q | (one_ok ? (8'd1 << bit_position_q) : 8'd0);

	// Frame state after taking the current symbol.
	always_comb begin
		symbol_count_nx  = symbol_count_q;
		header_good_nx   = header_good_q;
		shift_byte_nx    = shift_byte_q;
		bit_position_nx  = bit_position_q;
		pending_err_nx   = pending_err_q;
		committed_err_nx = committed_err_q;
		bytes_done_nx    = bytes_done_q;
		byte_sum_nx      = byte_sum_q;
		last_byte_nx     = last_byte_q;
		low_word_nx      = low_word_q;
		byte_zero_nx     = byte_zero_q;
		byte_five_nx     = byte_five_q;

		if (symbol_count_q != '1) begin
			symbol_count_nx = symbol_count_q + 1'b1;
		end

		if (symbol_count_q == '0) begin
			header_good_nx = hdr_ok;
		end else if (32'(bytes_done_q) < 32'(MAX_BYTES)) begin
			shift_byte_nx  = shift_set;
			pending_err_nx = pending_err_q | !mark_ok | (!one_ok && !zero_ok);
			if (bit_position_q == 3'd7) begin
				// A whole byte is complete.
				committed_err_nx = committed_err_q | pending_err_nx;
				byte_sum_nx      = byte_sum_q + last_byte_q;
				last_byte_nx     = shift_set;
				for (int k = 0; k < 4; k++) begin
					if (bytes_done_q == BYTE_W'(k)) begin
						low_word_nx[8*k +: 8] = shift_set;
					end
				end
				if (bytes_done_q == BYTE_W'(0)) begin
					byte_zero_nx = shift_set;
				end
				if (bytes_done_q == BYTE_W'(5)) begin
					byte_five_nx = shift_set;
				end
				bytes_done_nx   = bytes_done_q + 1'b1;
				bit_position_nx = 3'd0;
				shift_byte_nx   = 8'd0;
				pending_err_nx  = 1'b0;
			end else begin
				bit_position_nx = bit_position_q + 1'b1;
			end
		end
	end

	// Frame verdict from the updated state.
	assign expect_sum = 8'h00 - byte_sum_nx;

	always_comb begin
		if (symbol_count_nx <= cfg.min_data_bits) begin
			status = ST_SHORT;
		end else if (!header_good_nx || (5'(bytes_done_nx) < cfg.min_frame_bytes) ||
		             committed_err_nx) begin
			status = ST_FAIL;
		end else begin
			status = ST_OK;
		end

		result.status = status;
		if (status == ST_OK) begin
			result.checksum_good = (expect_sum == last_byte_nx);
			result.byte_count    = 5'(bytes_done_nx);
			result.command_byte  = (bytes_done_nx > BYTE_W'(5)) ? byte_five_nx : byte_zero_nx;
			result.first_word    = low_word_nx;
		end else begin
			result.checksum_good = 1'b0;
			result.byte_count    = 5'd0;
			result.command_byte  = 8'd0;
			result.first_word    = 32'd0;
		end
	end

	// State registers; the frame-end symbol clears everything.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbol_count_q  <= '0;
			header_good_q   <= 1'b0;
			shift_byte_q    <= 8'd0;
			bit_position_q  <= 3'd0;
			pending_err_q   <= 1'b0;
			committed_err_q <= 1'b0;
			bytes_done_q    <= '0;
			byte_sum_q      <= 8'd0;
			last_byte_q     <= 8'd0;
			low_word_q      <= 32'd0;
			byte_zero_q     <= 8'd0;
			byte_five_q     <= 8'd0;
		end else if (advance) begin
			if (sym.frame_end) begin
				symbol_count_q  <= '0;
				header_good_q   <= 1'b0;
				shift_byte_q    <= 8'd0;
				bit_position_q  <= 3'd0;
				pending_err_q   <= 1'b0;
				committed_err_q <= 1'b0;
				bytes_done_q    <= '0;
				byte_sum_q      <= 8'd0;
				last_byte_q     <= 8'd0;
				low_word_q      <= 32'd0;
				byte_zero_q     <= 8'd0;
				byte_five_q     <= 8'd0;
			end else begin
				symbol_count_q  <= symbol_count_nx;
				header_good_q   <= header_good_nx;
				shift_byte_q    <= shift_byte_nx;
				bit_position_q  <= bit_position_nx;
				pending_err_q   <= pending_err_nx;
				committed_err_q <= committed_err_nx;
				bytes_done_q    <= bytes_done_nx;
				byte_sum_q      <= byte_sum_nx;
				last_byte_q     <= last_byte_nx;
				low_word_q      <= low_word_nx;
				byte_zero_q     <= byte_zero_nx;
				byte_five_q     <= byte_five_nx;
			end
		end
	end

endmodule

// ===== hdl/ir_pulse_distance_frame_decoder.sv =====
`timescale 1ns / 1ps

// Pulse-distance infrared frame decoder. Each input item is one symbol (mark
// and space durations in ticks plus a frame-end flag); the first symbol of a
// frame is checked against the header, later ones are decoded into bits,
// LSB first, and packed into whole bytes. On the frame-end symbol one result
// item is produced with the status, byte count, command byte, first four
// bytes and the checksum verdict, and the frame state is cleared. The block
// takes one symbol per clock cycle while the input is not stalled: a symbol
// is registered on input, its matches and state update are worked out from
// that register, and a frame result is written into the output register
// when its frame-end symbol moves on. Input is stalled only while a finished
// result waits at a stalled output and the next frame end arrives.
// Configuration registers take a write in any cycle and should be changed
// only while no frame is in flight.
module ir_pulse_distance_frame_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sym_valid,
	output logic                          sym_stall,
	input  ipd_pkg::sym_t                 sym_item,
	output logic                          res_valid,
	input  logic                          res_stall,
	output ipd_pkg::res_t                 res_item,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ipd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ipd_pkg::TICK_W-1:0]    cfg_data
);
	import ipd_pkg::*;

	cfg_t cfg;
	sym_t sym_s1;
	logic sym_valid_s1;
	logic advance;
	logic accept;
	res_t result;
	res_t res_q;
	logic res_valid_q;

	ipd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The registered symbol moves on unless it ends a frame whose result
	// slot is still occupied by a stalled result.
	assign advance   = sym_valid_s1 &&
	                   (!sym_s1.frame_end || !res_valid_q || !res_stall);
	assign sym_stall = sym_valid_s1 && !advance;
	assign accept    = sym_valid && !sym_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_valid_s1 <= 1'b0;
		end else if (accept) begin
			sym_valid_s1 <= 1'b1;
		end else if (advance) begin
			sym_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sym_s1 <= sym_item;
		end
	end

	ipd_frame_state u_state (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.advance (advance),
		.sym     (sym_s1),
		.result  (result)
	);

	// Output register for one frame result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && sym_s1.frame_end) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && sym_s1.frame_end) begin
			res_q <= result;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	import ipd_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int ITEM_TARGET    = 80;
	localparam int FRAME_TARGET   = 6;
	localparam int PRINT_LIMIT    = 40;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 sym_valid = 1'b0;
	logic                 sym_stall;
	sym_t                 sym_item  = '0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	res_t                 res_item;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [TICK_W-1:0]    cfg_data  = '0;

	// Shadow copy of the register file, updated as each write is accepted.
	cfg_t regs;

	// Frame decoding state mirrored from the block.
	int         sym_count;
	bit         hdr_ok;
	logic [7:0] shift_reg;
	logic [2:0] bit_pos;
	bit         pend_err;
	bit         byte_err;
	int         nbytes;
	logic [7:0] sum8;
	logic [7:0] last8;
	logic [31:0] word0;
	logic [7:0] byte0;
	logic [7:0] byte5;

	res_t frames_due [$];
	int   frames_predicted = 0;
	int   items_sent = 0;
	int   mismatches = 0;
	int   idle_cycles = 0;
	int   stall_left = 0;
	bit   quiet = 1'b0;
	bit   calm = 1'b0;

	ir_pulse_distance_frame_decoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.sym_valid (sym_valid),
		.sym_stall (sym_stall),
		.sym_item  (sym_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Clock generation.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic cfg_t default_regs();
		cfg_t c;
		c.header_mark_ticks  = 15'd3324;
		c.header_space_ticks = 15'd1574;
		c.bit_mark_ticks     = 15'd448;
		c.one_space_ticks    = 15'd1182;
		c.zero_space_ticks   = 15'd390;
		c.match_tolerance    = 15'd150;
		c.min_data_bits      = 12'd48;
		c.min_frame_bytes    = 5'd6;
		return c;
	endfunction

	function automatic bit within_tol(input logic [14:0] got, input logic [14:0] want);
		int unsigned diff;
		diff = (got >= want) ? 32'(got - want) : 32'(want - got);
		return diff <= regs.match_tolerance;
	endfunction

	// A duration that lies within the current tolerance of the target.
	function automatic logic [14:0] near_to(input logic [14:0] target);
		int off;
		int v;
		off = $urandom_range(0, regs.match_tolerance);
		v = $urandom_range(0, 1) ? int'(target) + off : int'(target) - off;
		if (v < 0)
			v = 0;
		if (v > 32767)
			v = 32767;
		return v[14:0];
	endfunction

	task automatic clear_frame_state();
		sym_count = 0;
		hdr_ok    = 1'b0;
		shift_reg = '0;
		bit_pos   = '0;
		pend_err  = 1'b0;
		byte_err  = 1'b0;
		nbytes    = 0;
		sum8      = '0;
		last8     = '0;
		word0     = '0;
		byte0     = '0;
		byte5     = '0;
	endtask

	// Advance the decoder by one accepted symbol; a frame end queues its result.
	task automatic decode_symbol(input sym_t s);
		res_t r;
		int   idx;
		idx = sym_count;
		if (sym_count < 4095)
			sym_count++;
		if (idx == 0) begin
			hdr_ok = within_tol(s.mark_ticks, regs.header_mark_ticks) &&
			         within_tol(s.space_ticks, regs.header_space_ticks);
		end else if (nbytes < MAX_BYTES) begin
			if (!within_tol(s.mark_ticks, regs.bit_mark_ticks))
				pend_err = 1'b1;
			// A space close to both values is taken as a one.
			if (within_tol(s.space_ticks, regs.one_space_ticks))
				shift_reg[bit_pos] = 1'b1;
			else if (!within_tol(s.space_ticks, regs.zero_space_ticks))
				pend_err = 1'b1;
			if (bit_pos == 3'd7) begin
				byte_err = byte_err | pend_err;
				sum8     = sum8 + last8;
				last8    = shift_reg;
				if (nbytes < 4)
					word0[8*nbytes +: 8] = shift_reg;
				if (nbytes == 0)
					byte0 = shift_reg;
				if (nbytes == 5)
					byte5 = shift_reg;
				nbytes++;
				bit_pos   = '0;
				shift_reg = '0;
				pend_err  = 1'b0;
			end else begin
				bit_pos++;
			end
		end
		if (s.frame_end) begin
			r = '0;
			if (sym_count <= regs.min_data_bits) begin
				r.status = ST_SHORT;
			end else if (!hdr_ok || nbytes < regs.min_frame_bytes || byte_err) begin
				r.status = ST_FAIL;
			end else begin
				r.status        = ST_OK;
				r.checksum_good = ((8'd0 - sum8) == last8);
				r.byte_count    = 5'(nbytes);
				r.command_byte  = (nbytes > 5) ? byte5 : byte0;
				r.first_word    = word0;
			end
			frames_due.push_back(r);
			frames_predicted++;
			clear_frame_state();
		end
	endtask

	task automatic report(input string what, input logic [47:0] got, input logic [47:0] want);
		if (mismatches < PRINT_LIMIT)
			$display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic check_frame(input res_t got);
		res_t want;
		if (frames_due.size() == 0) begin
			report("result with no frame pending", got, '0);
			return;
		end
		want = frames_due.pop_front();
		if (got.status != want.status)
			report("status", 48'(got.status), 48'(want.status));
		if (got.checksum_good != want.checksum_good)
			report("checksum_good", 48'(got.checksum_good), 48'(want.checksum_good));
		if (got.byte_count != want.byte_count)
			report("byte_count", 48'(got.byte_count), 48'(want.byte_count));
		if (got.command_byte != want.command_byte)
			report("command_byte", 48'(got.command_byte), 48'(want.command_byte));
		if (got.first_word != want.first_word)
			report("first_word", 48'(got.first_word), 48'(want.first_word));
	endtask

	// Result side: check each accepted item and stall in random bursts.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			check_frame(res_item);
		if (!quiet && stall_left > 0) begin
			stall_left--;
			res_stall <= 1'b1;
		end else if (arst_n && !quiet && !calm && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 17) - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	// Watchdog on cycles in which no handshake completes.
	always @(posedge clk) begin
		if (!arst_n || (sym_valid && !sym_stall) || (res_valid && !res_stall) ||
		    (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("ir_pulse_distance_frame_decoder regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Send one symbol, with an occasional idle burst in front of it.
	task automatic send_symbol(input sym_t s);
		int gap;
		if (!quiet && !calm && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 17);
			sym_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sym_valid <= 1'b1;
		sym_item  <= s;
		do @(posedge clk); while (sym_stall);
		decode_symbol(s);
		items_sent++;
	endtask

	// One frame built against the current timings: header, then n_data bits.
	// With sum_ok the last whole byte carries the checksum; from data symbol
	// noisy_from on, noise_pct percent of symbols get a random duration.
	task automatic send_frame(input int n_data, input bit bad_header, input bit sum_ok,
	                          input int noise_pct, input int noisy_from);
		logic [7:0] payload [MAX_BYTES];
		logic [7:0] total;
		int         whole;
		bit         one;
		sym_t       s;
		whole = (n_data / 8 > MAX_BYTES) ? MAX_BYTES : n_data / 8;
		total = '0;
		for (int b = 0; b < MAX_BYTES; b++)
			payload[b] = 8'($urandom);
		if (sum_ok && whole > 0) begin
			for (int b = 0; b < whole - 1; b++)
				total = total + payload[b];
			payload[whole-1] = 8'd0 - total;
		end
		s.mark_ticks  = bad_header ? 15'($urandom) : near_to(regs.header_mark_ticks);
		s.space_ticks = near_to(regs.header_space_ticks);
		s.frame_end   = (n_data == 0);
		send_symbol(s);
		for (int i = 0; i < n_data; i++) begin
			one = (i < 8 * whole) ? payload[i/8][i%8] : 1'($urandom);
			s.mark_ticks  = near_to(regs.bit_mark_ticks);
			s.space_ticks = one ? near_to(regs.one_space_ticks) : near_to(regs.zero_space_ticks);
			if (i >= noisy_from && $urandom_range(1, 100) <= noise_pct) begin
				if ($urandom_range(0, 1))
					s.mark_ticks = 15'($urandom);
				else
					s.space_ticks = 15'($urandom);
			end
			s.frame_end = (i == n_data - 1);
			send_symbol(s);
		end
	endtask

	// Let every expected result arrive and the pipeline empty.
	task automatic settle();
		sym_valid <= 1'b0;
		while (frames_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [14:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_HEADER_MARK:  regs.header_mark_ticks  = data;
			CFG_HEADER_SPACE: regs.header_space_ticks = data;
			CFG_BIT_MARK:     regs.bit_mark_ticks     = data;
			CFG_ONE_SPACE:    regs.one_space_ticks    = data;
			CFG_ZERO_SPACE:   regs.zero_space_ticks   = data;
			CFG_TOLERANCE:    regs.match_tolerance    = data;
			CFG_MIN_BITS:     regs.min_data_bits      = data[11:0];
			CFG_MIN_BYTES:    regs.min_frame_bytes    = data[4:0];
			default:          ;
		endcase
	endtask

	// Write every register once the block is idle; the unused upper bits of
	// the narrow registers and an unused index get random data.
	task automatic load_regs(input cfg_t c);
		settle();
		write_reg(CFG_HEADER_MARK, c.header_mark_ticks);
		write_reg(CFG_HEADER_SPACE, c.header_space_ticks);
		write_reg(CFG_BIT_MARK, c.bit_mark_ticks);
		write_reg(CFG_ONE_SPACE, c.one_space_ticks);
		write_reg(CFG_ZERO_SPACE, c.zero_space_ticks);
		write_reg(CFG_TOLERANCE, c.match_tolerance);
		write_reg(CFG_MIN_BITS, {3'($urandom), c.min_data_bits});
		write_reg(CFG_MIN_BYTES, {10'($urandom), c.min_frame_bytes});
		write_reg(CFG_IDX_W'($urandom_range(8, 15)), 15'($urandom));
		cfg_valid <= 1'b0;
	endtask

	function automatic cfg_t random_regs();
		cfg_t c;
		c = default_regs();
		if ($urandom_range(0, 1)) begin
			c.header_mark_ticks  = 15'($urandom);
			c.header_space_ticks = 15'($urandom);
			c.bit_mark_ticks     = 15'($urandom);
			c.one_space_ticks    = 15'($urandom);
			c.zero_space_ticks   = 15'($urandom);
		end
		case ($urandom_range(0, 3))
			0:       c.match_tolerance = '0;
			1:       c.match_tolerance = 15'($urandom);
			default: c.match_tolerance = 15'($urandom_range(1, 400));
		endcase
		c.min_data_bits   = 12'($urandom_range(0, 30));
		c.min_frame_bytes = 5'($urandom_range(0, 4));
		return c;
	endfunction

	// Reset timings: good and bad frames around the default thresholds.
	task automatic test_default_frames();
		send_frame(48, 1'b0, 1'b1, 0, 0);
		send_frame(47, 1'b0, 1'b1, 0, 0);
		send_frame(48, 1'b0, 1'b0, 0, 0);
		send_frame(48, 1'b1, 1'b1, 0, 0);
	endtask

	// Each status path, errors past the checked bits and the byte cap.
	task automatic test_status_cases();
		cfg_t c;
		c = default_regs();
		c.min_data_bits   = 12'd8;
		c.min_frame_bytes = 5'd2;
		load_regs(c);
		send_frame(4, 1'b0, 1'b1, 0, 0);
		send_frame(24, 1'b1, 1'b1, 0, 0);
		send_frame(15, 1'b0, 1'b1, 0, 0);
		send_frame(24, 1'b0, 1'b1, 100, 8);
		send_frame(20, 1'b0, 1'b1, 100, 16);
		send_frame(140, 1'b0, 1'b1, 100, 128);
	endtask

	// One and zero spaces so close that a zero also matches a one.
	task automatic test_both_spaces_match();
		cfg_t c;
		c = default_regs();
		c.one_space_ticks = 15'd400;
		c.min_data_bits   = 12'd4;
		c.min_frame_bytes = 5'd1;
		load_regs(c);
		send_frame(24, 1'b0, 1'b1, 0, 0);
	endtask

	// No byte required: a header alone passes with a good checksum.
	task automatic test_zero_bytes();
		cfg_t c;
		c = default_regs();
		c.min_data_bits   = '0;
		c.min_frame_bytes = '0;
		load_regs(c);
		send_frame(0, 1'b0, 1'b1, 0, 0);
		send_frame(5, 1'b0, 1'b1, 0, 0);
	endtask

	// Lowest and highest register values and extreme durations.
	task automatic test_field_extremes();
		cfg_t c;
		c = '0;
		load_regs(c);
		send_frame(16, 1'b0, 1'b1, 0, 0);
		send_symbol('{mark_ticks: 15'h7fff, space_ticks: 15'h7fff, frame_end: 1'b1});
		c.header_mark_ticks  = 15'h7fff;
		c.header_space_ticks = 15'h7fff;
		c.bit_mark_ticks     = 15'h7fff;
		c.one_space_ticks    = 15'h7fff;
		c.zero_space_ticks   = 15'h7fff;
		c.match_tolerance    = 15'h7fff;
		c.min_data_bits      = '0;
		c.min_frame_bytes    = 5'd16;
		load_regs(c);
		send_frame(128, 1'b0, 1'b1, 0, 0);
		send_symbol('{mark_ticks: '0, space_ticks: '0, frame_end: 1'b1});
	endtask

	// Phases of random settings, mostly well-formed frames with some noise.
	task automatic test_random_traffic();
		int   items0;
		int   frames0;
		int   kind;
		int   n;
		cfg_t c;
		items0  = items_sent;
		frames0 = frames_predicted;
		while (items_sent - items0 < ITEM_TARGET || frames_predicted - frames0 < FRAME_TARGET) begin
			c = random_regs();
			load_regs(c);
			calm = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(2, 6)) begin
				kind = $urandom_range(0, 9);
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 140) :
				    $urandom_range(0, 8 * c.min_frame_bytes + 12);
				case (kind)
					7:       send_frame(n, 1'b0, 1'b1, 5, 0);
					8:       send_frame(n, 1'b1, 1'b1, 0, 0);
					9:       send_frame(n, 1'b1, 1'b0, 100, 0);
					default: send_frame(n, 1'b0, 1'($urandom), 0, 0);
				endcase
			end
		end
		calm = 1'b0;
	endtask

	// Closing stretch with no idling on either side.
	task automatic test_quiet_tail();
		cfg_t c;
		c = random_regs();
		load_regs(c);
		quiet = 1'b1;
		repeat (2)
			send_frame($urandom_range(0, 8 * c.min_frame_bytes + 12), 1'b0, 1'b1, 0, 0);
	endtask

	initial begin
		regs = default_regs();
		clear_frame_state();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_default_frames();
		test_status_cases();
		test_both_spaces_match();
		test_zero_bytes();
		test_field_extremes();
		test_random_traffic();
		test_quiet_tail();
		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("ir_pulse_distance_frame_decoder regression: pass");
		else
			$display("ir_pulse_distance_frame_decoder regression: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/ipd_pkg.sv
hdl/ipd_cfg_regs.sv
hdl/ipd_frame_state.sv
hdl/ir_pulse_distance_frame_decoder.sv
dv/testbench.sv
